// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the scheduler's sweep engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define PASC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define PASC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pasc_pkg.sv =====
// Shared constants, types and helpers of the periodic task alarm scheduler.
package pasc_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int PERIOD_BITS = 8;
    localparam int SLOT_SPAN   = 8;
    localparam int ALARM_W     = 8;
    localparam int MASK_W      = 8;
    localparam int TICK_W      = 32;
    localparam int TASKCNT_W   = 4;
    localparam int PERIODS_W   = 64;
    localparam int CFG_W       = 64;
    localparam int SLOT_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W       = $clog2(NUM_TASKS + 1);
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;

    localparam logic REG_TASK_COUNT   = 1'b0;
    localparam logic REG_TASK_PERIODS = 1'b1;

    typedef struct packed {
        logic             adv;
        logic             at_zero;
        logic             init;
        logic             marshal_base;
        logic [CNT_W-1:0] n;
    } job_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired;
        logic              marshal;
        logic              init;
    } res_t;

    function automatic logic [ALARM_W-1:0] slot_period(
        input logic [PERIODS_W-1:0] periods,
        input logic [SLOT_W-1:0]    slot
    );
        logic [ALARM_W-1:0] p;
        p = '0;
        p[PERIOD_BITS-1:0] = periods[SLOT_SPAN * slot +: PERIOD_BITS];
        return p;
    endfunction

endpackage

// ===== rtl/core/pasc_alarm_ram.sv =====
// Alarm counter memory: one write port, one registered read port, per-entry valid bits.
module pasc_alarm_ram
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [pasc_pkg::SLOT_W-1:0]  waddr,
    input  logic [pasc_pkg::ALARM_W-1:0] wdata,
    input  logic                         re,
    input  logic [pasc_pkg::SLOT_W-1:0]  raddr,
    output logic [pasc_pkg::ALARM_W-1:0] rdata
);

    logic [pasc_pkg::ALARM_W-1:0]   mem [pasc_pkg::NUM_TASKS];
    logic [pasc_pkg::NUM_TASKS-1:0] valid_reg;
    logic [pasc_pkg::ALARM_W-1:0]   rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pasc_sweep.sv =====
// Sweep engine: reads each active alarm per item; advance rewrites nonzero-period ones.
`include "assert_macros.svh"

module pasc_sweep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  pasc_pkg::job_t                 job,
    input  logic [pasc_pkg::PERIODS_W-1:0] periods,
    output logic                           busy,
    output logic                           res_valid,
    input  logic                           res_ready,
    output pasc_pkg::res_t                 res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     state_reg, state_next;
    pasc_pkg::job_t                 job_reg, job_next;
    logic [pasc_pkg::CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                           pend_reg, pend_next;
    logic [pasc_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [pasc_pkg::MASK_W-1:0]    mask_reg, mask_next;
    logic                           marshal_reg, marshal_next;

    logic                           issue;
    logic [pasc_pkg::ALARM_W-1:0]   alarm;
    logic [pasc_pkg::ALARM_W-1:0]   period;
    logic [pasc_pkg::ALARM_W-1:0]   alarm_dec;
    logic [pasc_pkg::ALARM_W-1:0]   alarm_new;
    logic                           fire;
    logic                           ram_we;

    pasc_alarm_ram u_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (alarm_new),
        .re    (issue),
        .raddr (rd_cnt_reg[pasc_pkg::SLOT_W-1:0]),
        .rdata (alarm)
    );

    always_comb
    begin
        issue     = (state_reg == ST_RUN) && (rd_cnt_reg < job_reg.n);
        period    = pasc_pkg::slot_period(periods, slot_reg);
        alarm_dec = (alarm != '0) ? alarm - pasc_pkg::ALARM_W'(1) : alarm;
        alarm_new = (alarm_dec == '0) ? period : alarm_dec;
        if (period == '0)
        begin
            fire = job_reg.at_zero;
        end
        else
        begin
            fire = (alarm != '0) && (alarm_dec == '0);
        end
        ram_we = pend_reg && job_reg.adv && (period != '0);
    end

    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        rd_cnt_next  = rd_cnt_reg;
        pend_next    = 1'b0;
        slot_next    = slot_reg;
        mask_next    = mask_reg;
        marshal_next = marshal_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    job_next     = job;
                    rd_cnt_next  = '0;
                    mask_next    = '0;
                    marshal_next = job.marshal_base;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    pend_next   = 1'b1;
                    slot_next   = rd_cnt_reg[pasc_pkg::SLOT_W-1:0];
                    rd_cnt_next = rd_cnt_reg + pasc_pkg::CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (alarm == pasc_pkg::ALARM_W'(1))
                    begin
                        marshal_next = 1'b1;
                    end
                    if (job_reg.adv && fire)
                    begin
                        mask_next = mask_reg | (pasc_pkg::MASK_W'(1) << slot_reg);
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        rd_cnt_reg  <= rd_cnt_next;
        slot_reg    <= slot_next;
        mask_reg    <= mask_next;
        marshal_reg <= marshal_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign res_valid   = (state_reg == ST_DONE);
    assign res.fired   = mask_reg;
    assign res.marshal = marshal_reg;
    assign res.init    = job_reg.init;

    `PASC_ASSERT_IMP(a_query_no_fire, res_valid && !job_reg.adv, mask_reg == '0,
        "query result carries fired tasks")
    `PASC_ASSERT_IMP(a_slot_active, pend_reg, slot_reg < job_reg.n,
        "processed slot beyond active task count")
    `PASC_ASSERT_NXT(a_start_runs, start && !busy, state_reg == ST_RUN && !pend_reg,
        "sweep did not begin after start")

endmodule

// ===== rtl/core/periodic_task_alarm_scheduler.sv =====
// Periodic task alarm scheduler top level: config, beat counter, sweep and output register.
//
// Usage:
//   Input stream (s_*): one beat per item, s_tdata[0] = advance. advance=1 lets one
//   scheduler beat elapse; advance=0 only queries the will-alarm flag.
//   Output stream (m_*): one beat per input item carrying the fired task mask, the
//   marshal flag and the tick count; m_tuser flags the initial tick.
//   Config port: cfg_we with cfg_index 0 writes task_count, index 1 the packed
//   periods. Write only while no item is in flight.
// Sweep:
//   The active task count n (0..8) sets the length of the sweep over the alarm
//   memory: one read per active slot, with the write-back of nonzero-period slots on
//   advance items, through a single port pair. One item is in work at a time;
//   s_tready is low until the result leaves the sweep.
// Reset:
//   rst_n clears the alarm counters (via valid bits), beat counter, initial-tick flag
//   and config registers; the first advance item afterwards is the initial tick.
// Stalls:
//   A finished result waits in the output register; the next item is accepted
//   meanwhile, and its sweep holds at completion until the register frees up.
module periodic_task_alarm_scheduler
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pasc_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pasc_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] advance, [7:1] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pasc_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] fired_mask, [8] marshal,
                                                       // [40:9] tick_count, [47:41] zero
    output logic                            m_tuser    // [0] init_tick
);

    logic [pasc_pkg::TASKCNT_W-1:0]  task_count_reg;
    logic [pasc_pkg::PERIODS_W-1:0]  task_periods_reg;
    logic [pasc_pkg::TICK_W-1:0]     beat_reg, beat_next;
    logic                            init_done_reg, init_done_next;
    logic                            out_valid_reg;
    logic [pasc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_user_reg;

    logic                            busy;
    logic                            accept;
    logic                            adv;
    logic                            is_beat;
    logic [pasc_pkg::CNT_W-1:0]      n_active;
    pasc_pkg::job_t                  job;
    logic                            res_valid;
    logic                            res_ready;
    pasc_pkg::res_t                  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg   <= '0;
            task_periods_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pasc_pkg::REG_TASK_COUNT:
                begin
                    task_count_reg <= cfg_wdata[pasc_pkg::TASKCNT_W-1:0];
                end
                pasc_pkg::REG_TASK_PERIODS:
                begin
                    task_periods_reg <= cfg_wdata[pasc_pkg::PERIODS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        accept  = s_tvalid && s_tready;
        adv     = s_tdata[0];
        is_beat = adv && init_done_reg;
        if (task_count_reg > pasc_pkg::TASKCNT_W'(pasc_pkg::NUM_TASKS))
        begin
            n_active = pasc_pkg::CNT_W'(pasc_pkg::NUM_TASKS);
        end
        else
        begin
            n_active = task_count_reg[pasc_pkg::CNT_W-1:0];
        end
        beat_next      = beat_reg;
        init_done_next = init_done_reg;
        if (accept)
        begin
            if (is_beat)
            begin
                beat_next = beat_reg + pasc_pkg::TICK_W'(1);
            end
            if (adv)
            begin
                init_done_next = 1'b1;
            end
        end
        job.adv          = adv;
        job.init         = adv && !init_done_reg;
        job.at_zero      = (beat_next == '0);
        job.n            = n_active;
        job.marshal_base = (n_active == '0) || (beat_next == '0);
    end

    assign s_tready  = !busy;
    assign res_ready = !out_valid_reg || m_tready;

    pasc_sweep u_sweep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .job       (job),
        .periods   (task_periods_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            init_done_reg <= init_done_next;
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {7'b0, beat_reg, res.marshal, res.fired};
            out_user_reg <= res.init;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
